### src/lvms_pkg.sv
// Shared types and constants for the lattice voter model sweep block.
`default_nettype none

package lvms_pkg;

  typedef enum logic {
    ACT_SEED   = 1'b0,
    ACT_UPDATE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_RIGHT = 2'd3
  } direction_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_READ
  } state_t;

  localparam logic [15:0] THRESHOLD_RESET = 16'd13107;

endpackage

`default_nettype wire

### src/lattice_voter_model_sweep.sv
// Top level of the lattice voter model sweep block.
//
// Voter model on a SIDE x SIDE torus of one-bit cells, visited in raster order.
// Input stream (s_*): one transfer per cell. s_tuser is the action (seed or
// update); s_tdata carries the random sample and the neighbour direction.
// Output stream (m_*): one transfer per input transfer, in order, giving the
// cell written and its value; m_tlast marks the last cell of a sweep, where
// the ones count and the all-ones, half and all-zeros flags are also valid.
// Configuration: cfg_we writes cfg_wdata into the seed threshold at once.
//
// Seeds and updates: a seed item is written and its result registered in the
// accept cycle, so seeds run at one item per cycle while the receiver keeps up.
// An update item reads its neighbour from the synchronous grid memory and
// finishes in ST_READ, with s_tready low, so no new item is taken until it is done.
// Reset: rst (synchronous) starts a clearing pass that zeroes both grids, one
// entry per cycle, with s_tready low; configuration writes are taken during it.
// A stalled receiver holds the output register; s_tready drops until the
// pending result leaves.
`default_nettype none

module lattice_voter_model_sweep
  import lvms_pkg::*;
#(
  parameter int SIDE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // sample[14:0], direction[16:15], zero pad
  input  wire logic        s_tuser,  // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // cell_row[3:0], cell_col[7:4], cell_value[8], ones_count[17:9],
  // all_ones[18], half_ones[19], all_zeros[20], zero pad
  output logic [23:0]      m_tdata,
  output logic             m_tlast   // sweep_last
);

  localparam int CELLS  = SIDE * SIDE;
  localparam int ROW_W  = $clog2(SIDE);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  state_t state, state_next;
  logic [ADDR_W-1:0] clear_addr;
  logic [ROW_W-1:0]  row, col;
  logic              current_is_b;
  logic [CNT_W-1:0]  running_ones;
  logic [15:0]       threshold;

  logic              s_accept, out_free, finish, fin_value, last;
  logic              q_a, q_b, we_a, we_b, wdata;
  logic [ADDR_W-1:0] waddr, raddr, cur_addr;
  logic [ROW_W-1:0]  nb_row, nb_col;
  logic [CNT_W-1:0]  cnt;
  logic              flag_all, flag_half, flag_zero;
  logic [ROW_W+3:0]  row_ext, col_ext;
  logic [CNT_W+8:0]  cnt_ext;
  action_t           action;
  direction_t        dir;

  assign action   = action_t'(s_tuser);
  assign dir      = direction_t'(s_tdata[16:15]);
  assign out_free = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  lvms_grids #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_grids (
    .clk   (clk),
    .we_a  (we_a),
    .we_b  (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .q_a   (q_a),
    .q_b   (q_b)
  );

  // Neighbour position with torus wrap.
  always_comb begin
    nb_row = row;
    nb_col = col;
    unique case (dir)
      DIR_UP:    nb_row = (row == '0) ? ROW_W'(SIDE - 1) : row - 1'b1;
      DIR_LEFT:  nb_col = (col == '0) ? ROW_W'(SIDE - 1) : col - 1'b1;
      DIR_DOWN:  nb_row = (row == ROW_W'(SIDE - 1)) ? '0 : row + 1'b1;
      DIR_RIGHT: nb_col = (col == ROW_W'(SIDE - 1)) ? '0 : col + 1'b1;
      default:   nb_row = row;
    endcase
  end

  assign cur_addr = ADDR_W'(row) * ADDR_W'(SIDE) + ADDR_W'(col);
  assign raddr    = ADDR_W'(nb_row) * ADDR_W'(SIDE) + ADDR_W'(nb_col);
  assign last     = (row == ROW_W'(SIDE - 1)) && (col == ROW_W'(SIDE - 1));

  // Sequencer: clearing pass, then seed in ST_RUN or update through ST_RUN and ST_READ.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    finish     = 1'b0;
    fin_value  = 1'b0;
    we_a       = 1'b0;
    we_b       = 1'b0;
    waddr      = cur_addr;
    wdata      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we_a  = 1'b1;
        we_b  = 1'b1;
        waddr = clear_addr;
        if (clear_addr == ADDR_W'(CELLS - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        s_tready  = out_free;
        fin_value = {1'b0, s_tdata[14:0]} < threshold;
        if (s_accept) begin
          if (action == ACT_SEED) begin
            // Seed writes the current grid.
            finish = 1'b1;
            wdata  = fin_value;
            we_a   = !current_is_b;
            we_b   = current_is_b;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        // Neighbour bit from the current grid lands in the next grid.
        finish     = 1'b1;
        fin_value  = current_is_b ? q_b : q_a;
        wdata      = fin_value;
        we_a       = current_is_b;
        we_b       = !current_is_b;
        state_next = ST_RUN;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign cnt       = running_ones + CNT_W'(fin_value);
  assign flag_all  = last && (cnt == CNT_W'(CELLS));
  assign flag_half = last && ({cnt, 1'b0} == (CNT_W + 1)'(CELLS));
  assign flag_zero = last && (cnt == '0);
  assign row_ext   = {4'b0, row};
  assign col_ext   = {4'b0, col};
  assign cnt_ext   = {9'b0, (last ? cnt : CNT_W'(0))};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      row          <= '0;
      col          <= '0;
      current_is_b <= 1'b0;
      running_ones <= '0;
      threshold    <= THRESHOLD_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
        if (last) begin
          row          <= '0;
          col          <= '0;
          running_ones <= '0;
          if (state == ST_READ) begin
            current_is_b <= !current_is_b;
          end
        end else begin
          running_ones <= cnt;
          if (col == ROW_W'(SIDE - 1)) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload: load on finish, hold otherwise.
  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {3'b0, flag_zero, flag_half, flag_all, cnt_ext[8:0], fin_value,
                  col_ext[3:0], row_ext[3:0]};
      m_tlast <= last;
    end
  end

endmodule

`default_nettype wire

### src/lvms_grids.sv
// Two one-bit lattice memories sharing write and read addresses.
`default_nettype none

module lvms_grids #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we_a,
  input  wire logic              we_b,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic              wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic                   q_a,
  output logic                   q_b
);

  logic mem_a [DEPTH];
  logic mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    q_a <= mem_a[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    q_b <= mem_b[raddr];
  end

endmodule

`default_nettype wire

### src/lvms_checker.sv
// Port-level checks for the lattice voter model sweep block, bound to the top.
`default_nettype none

module lvms_checker
  import lvms_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tlast
);

  // Reset starts the clearing pass with nothing pending.
  a_reset: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("input ready or output valid right after reset");

  // Input is only taken when the output register can take the result.
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input ready while a stalled result is held");

  // A seed result appears in the cycle after its transfer.
  a_seed_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == ACT_SEED)) |=> m_tvalid)
    else $error("seed result missing one cycle after transfer");

  // Sweep summary fields stay zero away from the sweep end.
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[20:9] == 12'd0))
    else $error("sweep summary nonzero on a middle cell");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

endmodule

bind lattice_voter_model_sweep lvms_checker u_lvms_checker (.*);

`default_nettype wire
